### design/spmr_pkg.sv
`timescale 1ns / 1ps
// Package for the shuffled Park-Miller generator: widths, constants,
// controller state type and the controller-to-datapath command bundle.
// No dependencies.
package spmr_pkg;

    localparam int TABLE_SIZE = 32;
    localparam int VAL_W      = 31;
    localparam int MULT_W     = 15;
    localparam int PROD_W     = VAL_W + MULT_W;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int WARM_STEPS = TABLE_SIZE + 8;
    localparam int CNT_W      = $clog2(WARM_STEPS);
    // slot = last_output / (1 + (M - 1) / TABLE_SIZE), a shift for power-of-two tables
    localparam int SLOT_SHIFT = VAL_W - IDX_W;

    localparam logic [MULT_W-1:0] MULTIPLIER = MULT_W'(16807);
    localparam logic [VAL_W-1:0]  MODULUS    = VAL_W'(2147483647);
    localparam logic [VAL_W-1:0]  SEED_RESET = VAL_W'(1931);
    localparam logic [VAL_W-1:0]  SEED_ONE   = VAL_W'(1);
    localparam logic [CNT_W-1:0]  STEP_FIRST = CNT_W'(WARM_STEPS - 1);
    localparam logic [CNT_W-1:0]  STEP_TABLE = CNT_W'(TABLE_SIZE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WMUL,
        ST_WRED,
        ST_MUL,
        ST_RED
    } state_t;

    typedef struct packed {
        logic             load_seed;
        logic             mul_en;
        logic             red_en;
        logic             warm_wr;
        logic             warm_last;
        logic             draw_rd;
        logic             draw_fin;
        logic [CNT_W-1:0] step;
    } cmd_t;

endpackage

### design/spmr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on spmr_pkg.
interface spmr_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink (input valid, input reseed, output ready);
endinterface

interface spmr_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [spmr_pkg::VAL_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);
endinterface

### design/spmr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spmr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/spmr_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences warm-up and draws, owns the handshakes.
// Depends on spmr_pkg and spmr_if.
module spmr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    spmr_req_if.sink        req,
    input  logic            rsp_ready,
    output logic            rsp_valid,
    output spmr_pkg::cmd_t  cmd
);

    spmr_pkg::state_t            state_reg, state_next;
    logic [spmr_pkg::CNT_W-1:0]  step_reg, step_next;
    logic                        seeded_reg, seeded_next;
    logic                        rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spmr_pkg::ST_IDLE;
            step_reg      <= '0;
            seeded_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            seeded_reg    <= seeded_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        seeded_next    = seeded_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req.ready      = 1'b0;
        cmd            = '0;
        cmd.step       = step_reg;

        unique case (state_reg)
            spmr_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = (req.reseed || !seeded_reg) ? spmr_pkg::ST_LOAD
                                                             : spmr_pkg::ST_MUL;
                end
            end
            spmr_pkg::ST_LOAD:
            begin
                cmd.load_seed = 1'b1;
                step_next     = spmr_pkg::STEP_FIRST;
                state_next    = spmr_pkg::ST_WMUL;
            end
            spmr_pkg::ST_WMUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = spmr_pkg::ST_WRED;
            end
            spmr_pkg::ST_WRED:
            begin
                cmd.red_en  = 1'b1;
                cmd.warm_wr = (step_reg < spmr_pkg::STEP_TABLE);
                if (step_reg == '0)
                begin
                    cmd.warm_last = 1'b1;
                    seeded_next   = 1'b1;
                    state_next    = spmr_pkg::ST_MUL;
                end
                else
                begin
                    step_next  = step_reg - spmr_pkg::CNT_W'(1);
                    state_next = spmr_pkg::ST_WMUL;
                end
            end
            spmr_pkg::ST_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.draw_rd = 1'b1;
                state_next  = spmr_pkg::ST_RED;
            end
            spmr_pkg::ST_RED:
            begin
                // hold here while the previous result is still unread
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.red_en     = 1'b1;
                    cmd.draw_fin   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = spmr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spmr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/spmr_dp.sv
`timescale 1ns / 1ps
// Datapath: seed register, Lehmer multiply and Mersenne reduction,
// last-output register, shuffle table RAM and result register.
// Depends on spmr_pkg and spmr_ram.
module spmr_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seed_value_wr_en,
    input  logic [spmr_pkg::VAL_W-1:0]  seed_value_wr_data,
    input  spmr_pkg::cmd_t              cmd,
    output logic [spmr_pkg::VAL_W-1:0]  random_value
);

    logic [spmr_pkg::VAL_W-1:0]  seed_reg;
    logic [spmr_pkg::VAL_W-1:0]  gen_reg, gen_next;
    logic [spmr_pkg::PROD_W-1:0] prod_reg;
    logic [spmr_pkg::VAL_W-1:0]  last_reg;
    logic [spmr_pkg::VAL_W-1:0]  out_reg;
    logic [spmr_pkg::VAL_W:0]    fold;
    logic [spmr_pkg::VAL_W-1:0]  red;
    logic [spmr_pkg::VAL_W-1:0]  seed_eff;
    logic [spmr_pkg::IDX_W-1:0]  slot;
    logic                        ram_wr_en;
    logic [spmr_pkg::IDX_W-1:0]  ram_wr_addr;
    logic [spmr_pkg::VAL_W-1:0]  ram_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= spmr_pkg::SEED_RESET;
        end
        else if (seed_value_wr_en)
        begin
            seed_reg <= seed_value_wr_data;
        end
    end

    // zero and 2^31-1 would lock the generator at zero
    assign seed_eff = (seed_reg == '0 || seed_reg == spmr_pkg::MODULUS) ? spmr_pkg::SEED_ONE
                                                                         : seed_reg;

    // 2^31 == 1 mod M, so fold the high part onto the low part
    assign fold = {1'b0, prod_reg[spmr_pkg::VAL_W-1:0]}
                + (spmr_pkg::VAL_W + 1)'(prod_reg[spmr_pkg::PROD_W-1:spmr_pkg::VAL_W]);
    assign red  = (fold >= {1'b0, spmr_pkg::MODULUS})
                ? spmr_pkg::VAL_W'(fold - {1'b0, spmr_pkg::MODULUS})
                : fold[spmr_pkg::VAL_W-1:0];

    assign slot = last_reg[spmr_pkg::VAL_W-1:spmr_pkg::SLOT_SHIFT];

    always_comb
    begin
        gen_next = gen_reg;
        if (cmd.load_seed)
        begin
            gen_next = seed_eff;
        end
        else if (cmd.red_en)
        begin
            gen_next = red;
        end
    end

    always_ff @(posedge clk)
    begin
        gen_reg <= gen_next;
        if (cmd.mul_en)
        begin
            prod_reg <= spmr_pkg::PROD_W'(gen_reg)
                      * spmr_pkg::PROD_W'(spmr_pkg::MULTIPLIER);
        end
        if (cmd.warm_last)
        begin
            last_reg <= red;
        end
        else if (cmd.draw_fin)
        begin
            last_reg <= ram_rd_data;
            out_reg  <= ram_rd_data;
        end
    end

    assign ram_wr_en   = cmd.warm_wr || cmd.draw_fin;
    assign ram_wr_addr = cmd.draw_fin ? slot : cmd.step[spmr_pkg::IDX_W-1:0];

    spmr_ram #(
        .WIDTH (spmr_pkg::VAL_W),
        .DEPTH (spmr_pkg::TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (red),
        .rd_en   (cmd.draw_rd),
        .rd_addr (slot),
        .rd_data (ram_rd_data)
    );

    assign random_value = out_reg;

endmodule

### design/shuffled_park_miller_rng_top.sv
`timescale 1ns / 1ps
// Top level of the shuffled Park-Miller generator.
// Depends on spmr_pkg, spmr_if, spmr_ctrl, spmr_dp.
//
// Usage:
//   req channel (valid/ready) carries one item per draw; reseed = 1 reloads
//   the generator from the seed and refills the 32-entry shuffle table first.
//   rsp channel (valid/ready) returns one 31-bit random_value per item.
//   seed_value_wr_en / seed_value_wr_data write the seed; it takes effect at
//   the next reseed. Write it only while the block is idle.
// Sequence:
//   A plain draw multiplies with the table read, then folds with write-back
//   and raises the result; the controller then returns to the accept state,
//   so a new item is taken only once the previous one has finished.
//   A reseed first loads the seed, then runs forty multiply/fold steps of the
//   shared Lehmer unit, the last 32 filling the table RAM one entry per step.
// Reset:
//   Seed returns to 1931 and the generator is unseeded, so the first item
//   after reset always runs the warm-up whatever reseed says.
// Stalls:
//   A new item is accepted while a result waits; that item then holds in its
//   final step until the waiting result has been taken.
module shuffled_park_miller_rng_top (
    input  logic                        clk,
    input  logic                        rst_n,
    spmr_req_if.sink                    req,
    spmr_rsp_if.source                  rsp,
    input  logic                        seed_value_wr_en,
    input  logic [spmr_pkg::VAL_W-1:0]  seed_value_wr_data
);

    spmr_pkg::cmd_t cmd;

    spmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .cmd       (cmd)
    );

    spmr_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .seed_value_wr_en   (seed_value_wr_en),
        .seed_value_wr_data (seed_value_wr_data),
        .cmd                (cmd),
        .random_value       (rsp.random_value)
    );

endmodule

### bench/shuffled_park_miller_rng_top_test.sv
`timescale 1ns / 1ps
// Testbench for shuffled_park_miller_rng_top: directed and random draw requests,
// seed writes between phases, each result checked against a behavioural predictor.
// Depends on spmr_pkg, spmr_if and the design sources.
module shuffled_park_miller_rng_top_test;

    localparam int unsigned      SEED_AT_RESET = 1931;
    localparam longint unsigned  LEHMER_MUL    = 16807;
    localparam longint unsigned  LEHMER_MOD    = 64'd2147483647;
    localparam int unsigned      SLOT_DIVISOR  = 1 + (2147483646 / spmr_pkg::TABLE_SIZE);
    localparam int               LIMIT_CYCLES  = 1000000;
    localparam int               LONG_HOLD     = 300;
    localparam int               RANDOM_ITEMS  = 1500;
    localparam int               QUIET_ITEMS   = 200;
    localparam int               TAIL_CYCLES   = 20;

    class draw_scoreboard;
        logic [spmr_pkg::VAL_W-1:0] seed_reg = spmr_pkg::VAL_W'(SEED_AT_RESET);
        logic [spmr_pkg::VAL_W-1:0] gen_val  = spmr_pkg::VAL_W'(1);
        logic [spmr_pkg::VAL_W-1:0] last_out = '0;
        logic [spmr_pkg::VAL_W-1:0] shuffle [spmr_pkg::TABLE_SIZE];
        logic [spmr_pkg::VAL_W-1:0] expected_values [$];
        int                         errors   = 0;

        function logic [spmr_pkg::VAL_W-1:0] lehmer(logic [spmr_pkg::VAL_W-1:0] x);
            longint unsigned prod;
            prod = longint'(x) * LEHMER_MUL;
            return spmr_pkg::VAL_W'(prod % LEHMER_MOD);
        endfunction

        // reload from the seed and refill the table; 2^31-1 is congruent to zero
        function void refill_table();
            logic [spmr_pkg::VAL_W-1:0] x;
            x = seed_reg;
            if (x == '0 || longint'(x) == LEHMER_MOD)
                x = spmr_pkg::VAL_W'(1);
            for (int n = spmr_pkg::TABLE_SIZE + 7; n >= 0; n--)
            begin
                x = lehmer(x);
                if (n < spmr_pkg::TABLE_SIZE)
                    shuffle[n] = x;
            end
            gen_val  = x;
            last_out = shuffle[0];
        endfunction

        function void set_seed(logic [spmr_pkg::VAL_W-1:0] v);
            seed_reg = v;
        endfunction

        function void note_request(logic reseed);
            int unsigned slot;
            if (reseed || last_out == '0)
                refill_table();
            gen_val = lehmer(gen_val);
            slot = int'(last_out) / SLOT_DIVISOR;
            if (slot >= spmr_pkg::TABLE_SIZE)
                slot = spmr_pkg::TABLE_SIZE - 1;
            last_out      = shuffle[slot];
            shuffle[slot] = gen_val;
            expected_values.push_back(last_out);
        endfunction

        function void check_result(logic [spmr_pkg::VAL_W-1:0] got);
            logic [spmr_pkg::VAL_W-1:0] want;
            if (expected_values.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item, expected none, actual random_value %0d",
                         $time, got);
            end
            else
            begin
                want = expected_values.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: random_value mismatch, expected %0d, actual %0d",
                             $time, want, got);
                end
            end
        endfunction

        function int outstanding();
            return expected_values.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       seed_value_wr_en;
    logic [spmr_pkg::VAL_W-1:0] seed_value_wr_data;

    spmr_req_if req ();
    spmr_rsp_if rsp ();

    shuffled_park_miller_rng_top uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .req                (req),
        .rsp                (rsp),
        .seed_value_wr_en   (seed_value_wr_en),
        .seed_value_wr_data (seed_value_wr_data)
    );

    draw_scoreboard sb;
    bit             hold_off = 1'b0;
    bit             quiet    = 1'b0;
    int             cycles   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // both handshakes observed in one process, request first
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
                sb.note_request(req.reseed);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                sb.check_result(rsp.random_value);
        end
    end

    // result side back-pressure
    initial
    begin
        int stall;
        int stall_pct;
        int mode_cycles;
        stall       = 0;
        stall_pct   = 20;
        mode_cycles = 0;
        rsp.ready   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            mode_cycles++;
            if (mode_cycles >= 400)
            begin
                mode_cycles = 0;
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 5;
                    2:       stall_pct = 20;
                    default: stall_pct = 50;
                endcase
            end
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off = 1'b0;
                stall    = 0;
            end
            else if (quiet)
                rsp.ready <= 1'b1;
            else if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                rsp.ready <= 1'b0;
                stall = $urandom_range(1, 10) - 1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // leaves valid high; the caller lowers it for a gap
    task automatic send_req(input logic rs);
        req.valid  <= 1'b1;
        req.reseed <= rs;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
    endtask

    task automatic pause_sender(input int n);
        req.valid  <= 1'b0;
        req.reseed <= 1'($urandom);
        repeat (n) @(posedge clk);
    endtask

    // step past the acceptance edge first so the monitor has noted the last accepted item
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_seed(input logic [spmr_pkg::VAL_W-1:0] v);
        seed_value_wr_en   <= 1'b1;
        seed_value_wr_data <= v;
        @(posedge clk);
        sb.set_seed(v);
        seed_value_wr_en   <= 1'b0;
        seed_value_wr_data <= spmr_pkg::VAL_W'($urandom);
    endtask

    function automatic logic [spmr_pkg::VAL_W-1:0] pick_seed();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return spmr_pkg::VAL_W'(2147483646);
            3:       return spmr_pkg::VAL_W'(1);
            default: return spmr_pkg::VAL_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int sent;
        int phase;
        int phase_len;
        int gap_pct;
        int reseed_pct;
        sent               = 0;
        phase              = 0;
        sb                 = new;
        rst_n              = 1'b0;
        req.valid          = 1'b0;
        req.reseed         = 1'b0;
        seed_value_wr_en   = 1'b0;
        seed_value_wr_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first draw after reset seeds from 1931 even without reseed
        send_req(1'b0);
        send_req(1'b0);
        send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);
        // a seed write alone must not reseed
        drain();
        write_seed('0);
        send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);
        drain();
        write_seed('1);
        send_req(1'b1);
        send_req(1'b0);
        drain();
        write_seed(spmr_pkg::VAL_W'(2147483646));
        send_req(1'b1);
        send_req(1'b1);
        send_req(1'b0);
        drain();
        write_seed(spmr_pkg::VAL_W'(1));
        send_req(1'b1);
        send_req(1'b0);
        drain();
        write_seed(spmr_pkg::VAL_W'('h2AAAAAAA));
        send_req(1'b1);
        drain();
        write_seed(spmr_pkg::VAL_W'('h55555555));
        send_req(1'b1);
        send_req(1'b0);
        drain();

        while (sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(50, 250);
            case ($urandom_range(0, 3))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                2:       gap_pct = 30;
                default: gap_pct = 60;
            endcase
            case ($urandom_range(0, 2))
                0:       reseed_pct = 2;
                1:       reseed_pct = 6;
                default: reseed_pct = 15;
            endcase
            drain();
            if ($urandom_range(0, 2) != 0)
                write_seed(pick_seed());
            // long receiver hold-off while requests keep coming
            if (phase == 3)
            begin
                hold_off = 1'b1;
                gap_pct  = 0;
            end
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                send_req($urandom_range(0, 99) < reseed_pct);
                sent++;
                if ($urandom_range(0, 99) < gap_pct)
                    pause_sender($urandom_range(1, 10));
            end
            phase++;
        end

        // closing stretch, no idling on either side
        quiet = 1'b1;
        for (int i = 0; i < QUIET_ITEMS; i++)
            send_req($urandom_range(0, 99) < 5);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
